// ----- hdl/mpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mpm_pkg;

  // Fixed field geometry of the stream items
  localparam int FIELD_BITS     = 52;
  localparam int IN_LIMBS       = 5;
  localparam int OUT_LIMBS      = 10;
  localparam int TDATA_IN_BITS  = ((2 * IN_LIMBS * FIELD_BITS + 7) / 8) * 8;
  localparam int TDATA_OUT_BITS = ((OUT_LIMBS * FIELD_BITS + 7) / 8) * 8;

  // Default arithmetic geometry
  localparam int LIMB_BITS_DEF = 52;
  localparam int NUM_LIMBS_DEF = 5;

  // Load enables of the two multiplier stages in a lane
  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
  } lane_ctl_t;

  // Load enables of the two column-sum stages
  typedef struct packed {
    logic ld_part;
    logic ld_col;
  } merge_ctl_t;

  // Headroom above a limb for a column sum plus its incoming carry
  function automatic int carry_bits(input int num_limbs);
    return $clog2(4 * num_limbs);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mpm_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpm_lane #(
  parameter int LIMB_BITS = mpm_pkg::LIMB_BITS_DEF
) (
  input  wire                       clk_i,
  input  wire  mpm_pkg::lane_ctl_t  ctl_i,
  input  wire  [LIMB_BITS-1:0]      a_i,
  input  wire  [LIMB_BITS-1:0]      b_i,
  output logic [2*LIMB_BITS-1:0]    prod_o
);

  localparam int H  = (LIMB_BITS + 1) / 2;
  localparam int HL = LIMB_BITS - H;
  localparam int PW = 2 * LIMB_BITS;

  logic [H-1:0]   a_lo, a_hi, b_lo, b_hi;
  logic [2*H-1:0] ll_d, lh_d, hl_d, hh_d;
  logic [2*H-1:0] ll_q, lh_q, hl_q, hh_q;
  logic [2*H:0]   mid;
  logic [PW-1:0]  prod_d, prod_q;

  // Split each limb into two half words
  assign a_lo = a_i[H-1:0];
  assign b_lo = b_i[H-1:0];
  assign a_hi = H'(a_i[LIMB_BITS-1:H]);
  assign b_hi = H'(b_i[LIMB_BITS-1:H]);

  // Four half-word products
  assign ll_d = {{H{1'b0}}, a_lo} * {{H{1'b0}}, b_lo};
  assign lh_d = {{H{1'b0}}, a_lo} * {{H{1'b0}}, b_hi};
  assign hl_d = {{H{1'b0}}, a_hi} * {{H{1'b0}}, b_lo};
  assign hh_d = {{H{1'b0}}, a_hi} * {{H{1'b0}}, b_hi};

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_mul) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
      hh_q <= hh_d;
    end
  end

  // Recombine the partial products into the full double-width product
  assign mid    = {1'b0, lh_q} + {1'b0, hl_q};
  assign prod_d = PW'(ll_q) + (PW'(mid) << H) + (PW'(hh_q) << (2 * H));

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_sum) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- hdl/mpm_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpm_merge #(
  parameter int LIMB_BITS = mpm_pkg::LIMB_BITS_DEF,
  parameter int NUM_LIMBS = mpm_pkg::NUM_LIMBS_DEF
) (
  input  wire                    clk_i,
  input  wire  mpm_pkg::merge_ctl_t ctl_i,
  input  wire  [2*LIMB_BITS-1:0] prod_i [NUM_LIMBS*NUM_LIMBS],
  output logic [LIMB_BITS+mpm_pkg::carry_bits(NUM_LIMBS)-1:0] col_o [2*NUM_LIMBS]
);

  localparam int CB = mpm_pkg::carry_bits(NUM_LIMBS);
  localparam int CW = LIMB_BITS + CB;
  localparam int NC = 2 * NUM_LIMBS;

  logic [CW-1:0] lo_d [NC];
  logic [CW-1:0] hi_d [NC];
  logic [CW-1:0] lo_q [NC];
  logic [CW-1:0] hi_q [NC];
  logic [CW-1:0] col_d [NC];
  logic [CW-1:0] col_q [NC];

  // Gather low halves of column k and high halves of column k-1
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      lo_d[k] = '0;
      hi_d[k] = '0;
      for (int i = 0; i < NUM_LIMBS; i++) begin
        for (int j = 0; j < NUM_LIMBS; j++) begin
          if (i + j == k) begin
            lo_d[k] = lo_d[k] + CW'(prod_i[i*NUM_LIMBS+j][LIMB_BITS-1:0]);
          end
          if (i + j + 1 == k) begin
            hi_d[k] = hi_d[k] + CW'(prod_i[i*NUM_LIMBS+j][2*LIMB_BITS-1:LIMB_BITS]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_part) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // Form the full column sums
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      col_d[k] = lo_q[k] + hi_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_col) begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// ----- hdl/mpm_carry.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mpm_carry #(
  parameter int LIMB_BITS = mpm_pkg::LIMB_BITS_DEF,
  parameter int NUM_LIMBS = mpm_pkg::NUM_LIMBS_DEF,
  parameter int LIMB_IDX  = 0
) (
  input  wire                   clk_i,
  input  wire                   ld_i,
  input  wire  [LIMB_BITS+mpm_pkg::carry_bits(NUM_LIMBS)-1:0] col_i [2*NUM_LIMBS],
  input  wire  [LIMB_BITS-1:0]  limb_i [2*NUM_LIMBS],
  input  wire  [mpm_pkg::carry_bits(NUM_LIMBS)-1:0] carry_i,
  output logic [LIMB_BITS+mpm_pkg::carry_bits(NUM_LIMBS)-1:0] col_o [2*NUM_LIMBS],
  output logic [LIMB_BITS-1:0]  limb_o [2*NUM_LIMBS],
  output logic [mpm_pkg::carry_bits(NUM_LIMBS)-1:0] carry_o
);

  localparam int CB = mpm_pkg::carry_bits(NUM_LIMBS);
  localparam int CW = LIMB_BITS + CB;
  localparam int NC = 2 * NUM_LIMBS;

  logic [CW-1:0]        sum;
  logic [LIMB_BITS-1:0] limb_d [NC];
  logic [LIMB_BITS-1:0] limb_q [NC];
  logic [CW-1:0]        col_q  [NC];
  logic [CB-1:0]        carry_q;

  // Add the incoming carry into this column and split off the next carry
  assign sum = col_i[LIMB_IDX] + CW'(carry_i);

  always_comb begin
    limb_d           = limb_i;
    limb_d[LIMB_IDX] = sum[LIMB_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      col_q   <= col_i;
      limb_q  <= limb_d;
      carry_q <= sum[CW-1:LIMB_BITS];
    end
  end

  assign col_o   = col_q;
  assign limb_o  = limb_q;
  assign carry_o = carry_q;

endmodule

`default_nettype wire

// ----- hdl/multiprecision_mul_5x52.sv -----
// Full-width multiplier for two unsigned operands of NUM_LIMBS limbs of
// LIMB_BITS bits each, returning the exact product as 2*NUM_LIMBS normalized
// limbs, least significant first. A new operand pair may be transferred in
// every cycle unless every stage is full and the output stalls; results leave
// one product per cycle while the receiver is ready. One multiplier lane per
// limb pair forms its product from four half-word multiplies and a recombining
// add (two stages), the column adder gathers the products by weight (two
// stages), and a chain of carry stages, one per product limb, normalizes the
// limbs from the least significant end. Every stage has its own valid bit and
// bubbles are squeezed out, so input is taken while a result still waits.
`timescale 1ns / 1ps
`default_nettype none

module multiprecision_mul_5x52 #(
  parameter int LIMB_BITS = mpm_pkg::LIMB_BITS_DEF,
  parameter int NUM_LIMBS = mpm_pkg::NUM_LIMBS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // a_limb_0 .. a_limb_4, b_limb_0 .. b_limb_4, 52 bits each
  input  wire  [mpm_pkg::TDATA_IN_BITS-1:0]   s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  // p_limb_0 .. p_limb_9, 52 bits each
  output logic [mpm_pkg::TDATA_OUT_BITS-1:0]  m_axis_tdata_o
);

  localparam int FW  = mpm_pkg::FIELD_BITS;
  localparam int L   = LIMB_BITS;
  localparam int N   = NUM_LIMBS;
  localparam int NC  = 2 * N;
  localparam int CB  = mpm_pkg::carry_bits(N);
  localparam int CW  = L + CB;
  localparam int NS  = 4 + NC;
  localparam int NSW = $clog2(NS + 1);

  logic [NS-1:0] v_q;
  logic [NS-1:0] ld;

  logic [L-1:0]   a_limb [N];
  logic [L-1:0]   b_limb [N];
  logic [2*L-1:0] prod   [N*N];
  logic [CW-1:0]  col_s   [NC+1][NC];
  logic [L-1:0]   limb_s  [NC+1][NC];
  logic [CB-1:0]  carry_s [NC+1];

  mpm_pkg::lane_ctl_t  lane_ctl;
  mpm_pkg::merge_ctl_t merge_ctl;

  // Stage loads: a stage advances when empty or when its successor advances
  always_comb begin
    ld[NS-1] = !v_q[NS-1] || m_axis_tready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v_q[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ld[i]) begin
          v_q[i] <= (i == 0) ? s_axis_tvalid_i : v_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_axis_tready_o = ld[0];
  assign m_axis_tvalid_o = v_q[NS-1];

  assign lane_ctl.ld_mul   = ld[0];
  assign lane_ctl.ld_sum   = ld[1];
  assign merge_ctl.ld_part = ld[2];
  assign merge_ctl.ld_col  = ld[3];

  // Cut or widen the operand fields to limb width
  for (genvar k = 0; k < N; k++) begin : g_in
    if (L <= FW) begin : g_cut
      assign a_limb[k] = s_axis_tdata_i[k*FW +: L];
      assign b_limb[k] = s_axis_tdata_i[(mpm_pkg::IN_LIMBS+k)*FW +: L];
    end else begin : g_ext
      assign a_limb[k] = {{(L-FW){1'b0}}, s_axis_tdata_i[k*FW +: FW]};
      assign b_limb[k] = {{(L-FW){1'b0}}, s_axis_tdata_i[(mpm_pkg::IN_LIMBS+k)*FW +: FW]};
    end
  end

  // One multiplier lane per limb pair
  for (genvar i = 0; i < N; i++) begin : g_row
    for (genvar j = 0; j < N; j++) begin : g_col
      mpm_lane #(
        .LIMB_BITS (L)
      ) u_lane (
        .clk_i  (clk_i),
        .ctl_i  (lane_ctl),
        .a_i    (a_limb[i]),
        .b_i    (b_limb[j]),
        .prod_o (prod[i*N+j])
      );
    end
  end

  // Sum the lane products by column weight
  mpm_merge #(
    .LIMB_BITS (L),
    .NUM_LIMBS (N)
  ) u_merge (
    .clk_i  (clk_i),
    .ctl_i  (merge_ctl),
    .prod_i (prod),
    .col_o  (col_s[0])
  );

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      limb_s[0][k] = '0;
    end
    carry_s[0] = '0;
  end

  // Normalize one limb per stage, least significant first
  for (genvar k = 0; k < NC; k++) begin : g_carry
    mpm_carry #(
      .LIMB_BITS (L),
      .NUM_LIMBS (N),
      .LIMB_IDX  (k)
    ) u_carry (
      .clk_i   (clk_i),
      .ld_i    (ld[4+k]),
      .col_i   (col_s[k]),
      .limb_i  (limb_s[k]),
      .carry_i (carry_s[k]),
      .col_o   (col_s[k+1]),
      .limb_o  (limb_s[k+1]),
      .carry_o (carry_s[k+1])
    );
  end

  // Pack the product limbs into the result fields
  always_comb begin
    m_axis_tdata_o = '0;
    for (int k = 0; k < NC; k++) begin
      m_axis_tdata_o[k*FW +: FW] = FW'(limb_s[NC][k]);
    end
  end

  // Track items in flight for checking
  logic [NSW-1:0] cnt_q;
  logic           in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + NSW'(in_xfer) - NSW'(out_xfer);
    end
  end

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == NSW'($countones(v_q)))
    else $error("in-flight count disagrees with stage valid bits");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q == {NS{1'b1}} && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while every stage is occupied and stalled");

  a_no_carry_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (carry_s[NC] == '0))
    else $error("carry left above the top product limb");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int FIELD_BITS     = mpm_pkg::FIELD_BITS;
  localparam int IN_LIMBS       = mpm_pkg::IN_LIMBS;
  localparam int OUT_LIMBS      = mpm_pkg::OUT_LIMBS;
  localparam int TDATA_IN_BITS  = mpm_pkg::TDATA_IN_BITS;
  localparam int TDATA_OUT_BITS = mpm_pkg::TDATA_OUT_BITS;

  typedef logic [FIELD_BITS-1:0] limb_t;
  typedef logic [IN_LIMBS-1:0][FIELD_BITS-1:0] operand_t;
  typedef logic [OUT_LIMBS-1:0][FIELD_BITS-1:0] product_t;

  localparam limb_t LIMB_MAX      = '1;
  localparam int    LATENCY       = 4 + 2 * IN_LIMBS;
  localparam int    CYCLE_LIMIT   = 200000;
  localparam int    RANDOM_ITEMS  = 450;
  localparam int    HOLDOFF_AT    = 150;
  localparam int    HOLDOFF_LEN   = 400;
  localparam int    REPORT_LIMIT  = 10;

  // Expected products in transfer order, checked limb by limb
  class product_scoreboard;
    product_t expected_products[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Exact 520-bit product of the two 260-bit operands
    function product_t predict_product(operand_t a, operand_t b);
      logic [2*IN_LIMBS*FIELD_BITS-1:0] wide_a;
      logic [2*IN_LIMBS*FIELD_BITS-1:0] wide_b;
      wide_a = {{(IN_LIMBS*FIELD_BITS){1'b0}}, a};
      wide_b = {{(IN_LIMBS*FIELD_BITS){1'b0}}, b};
      return product_t'(wide_a * wide_b);
    endfunction

    function void note_operands(logic [TDATA_IN_BITS-1:0] tdata);
      operand_t a;
      operand_t b;
      a = tdata[IN_LIMBS*FIELD_BITS-1:0];
      b = tdata[2*IN_LIMBS*FIELD_BITS-1:IN_LIMBS*FIELD_BITS];
      expected_products.push_back(predict_product(a, b));
    endfunction

    function void check_product(logic [TDATA_OUT_BITS-1:0] tdata);
      product_t got;
      product_t want;
      got = tdata[OUT_LIMBS*FIELD_BITS-1:0];
      if (expected_products.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected product transfer: %h", got);
        return;
      end
      want = expected_products.pop_front();
      for (int k = 0; k < OUT_LIMBS; k++) begin
        if (got[k] !== want[k]) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("p_limb_%0d mismatch: expected %h, got %h", k, want[k], got[k]);
        end
      end
    endfunction

    function int pending();
      return expected_products.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [TDATA_IN_BITS-1:0]  s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [TDATA_OUT_BITS-1:0] m_axis_tdata;

  product_scoreboard sb;
  int  accepted_in;
  int  cycles;
  bit  holdoff_done;

  multiprecision_mul_5x52 dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  // Clock and run limit
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    sb           = new();
    accepted_in  = 0;
    cycles       = 0;
    holdoff_done = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor both sides at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_operands(s_axis_tdata);
        accepted_in++;
      end
      if (m_axis_tvalid && m_axis_tready)
        sb.check_product(m_axis_tdata);
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic limb_t rand_limb();
    int    sel;
    limb_t v;
    sel = $urandom_range(0, 11);
    v   = limb_t'({$urandom, $urandom});
    case (sel)
      0: v = '0;
      1: v = LIMB_MAX;
      2: v = limb_t'(1);
      3: v = limb_t'(1) << $urandom_range(0, FIELD_BITS - 1);
      4: v = LIMB_MAX - limb_t'($urandom_range(0, 255));
      default: ;
    endcase
    return v;
  endfunction

  function automatic operand_t rand_operand();
    operand_t op;
    int       sel;
    sel = $urandom_range(0, 9);
    for (int k = 0; k < IN_LIMBS; k++)
      op[k] = (sel == 0) ? LIMB_MAX : (sel == 1) ? limb_t'({$urandom, $urandom}) : rand_limb();
    return op;
  endfunction

  // Offer one operand pair after a gap and hold it until transferred
  task automatic send_operands(operand_t a, operand_t b, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {b, a};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait for every outstanding product
  task automatic drain_products();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Receiver: random ready runs and stalls, one long hold-off, one burst window
  initial begin
    int ready_run;
    int stall_run;
    ready_run     = 0;
    stall_run     = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!holdoff_done && accepted_in >= HOLDOFF_AT) begin
        m_axis_tready = 1'b0;
        repeat (HOLDOFF_LEN) @(negedge clk_i);
        holdoff_done = 1'b1;
      end
      if (accepted_in >= 320 && accepted_in < 380) begin
        m_axis_tready = 1'b1;
      end else begin
        if (ready_run == 0 && stall_run == 0) begin
          ready_run = $urandom_range(1, 30);
          stall_run = pick_gap();
        end
        if (ready_run > 0) begin
          m_axis_tready = 1'b1;
          ready_run--;
        end else begin
          m_axis_tready = 1'b0;
          stall_run--;
        end
      end
    end
  end

  // Sender: directed corners, then random operand pairs
  initial begin
    operand_t zero_op;
    operand_t max_op;
    operand_t a;
    operand_t b;
    zero_op       = '0;
    max_op        = {IN_LIMBS{LIMB_MAX}};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_operands(zero_op, zero_op, 0);
    send_operands(max_op, max_op, 0);
    send_operands(zero_op, max_op, 1);
    send_operands(max_op, zero_op, 0);
    send_operands(operand_t'(1), max_op, 0);
    send_operands(max_op, operand_t'(1), 2);
    // Top bit of each operand: the product lands in the top limb
    a = '0;
    a[IN_LIMBS-1][FIELD_BITS-1] = 1'b1;
    send_operands(a, a, 0);
    send_operands({IN_LIMBS{52'hAAAAAAAAAAAAA}}, {IN_LIMBS{52'h5555555555555}}, 0);
    send_operands({IN_LIMBS{52'h5555555555555}}, {IN_LIMBS{52'h5555555555555}}, 0);
    // One full limb against a full operand, each limb in turn
    for (int k = 0; k < IN_LIMBS; k++) begin
      a    = '0;
      a[k] = LIMB_MAX;
      send_operands(a, max_op, 0);
    end
    // Single limbs whose product falls in one column
    for (int k = 0; k < IN_LIMBS; k++) begin
      a = '0;
      b = '0;
      a[k] = LIMB_MAX;
      b[IN_LIMBS-1-k] = LIMB_MAX;
      send_operands(a, b, k % 2);
    end
    drain_products();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 250) drain_products();
      send_operands(rand_operand(), rand_operand(), (i % 100 < 30) ? 0 : pick_gap());
    end
    drain_products();

    repeat (4 * LATENCY) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
